>>> rtl/bu2x_pkg.sv
// Shared types, constants and arithmetic helpers of the 2x bilinear upscaler.
package bu2x_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = 16;
  localparam int PIX_W = 8;
  localparam int SW_W = 13;
  localparam int SH_W = 16;
  localparam int CMP_W = (COL_W + 1 > SW_W) ? COL_W + 1 : SW_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = FIFO_AW + 1;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int NBLK = 4;

  localparam logic REG_SRC_WIDTH = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  localparam logic [SW_W-1:0] SRC_WIDTH_RST = SW_W'(1024);
  localparam logic [SH_W-1:0] SRC_HEIGHT_RST = SH_W'(1024);

  localparam logic [NBLK-1:0] BLK_UP_LEFT = 4'b0001;
  localparam logic [NBLK-1:0] BLK_UP_EDGE = 4'b0010;
  localparam logic [NBLK-1:0] BLK_ROW_LEFT = 4'b0100;
  localparam logic [NBLK-1:0] BLK_ROW_EDGE = 4'b1000;

  typedef struct packed {
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
  } geom_t;

  typedef struct packed {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] left_above;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic [NBLK-1:0]  blk;
  } job_t;

  function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    logic [PIX_W+1:0] s;
    s = {2'b00, a} + {2'b00, b} + (PIX_W+2)'(1);
    return s[PIX_W:1];
  endfunction

  function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c,
                                            input logic [PIX_W-1:0] d);
    logic [PIX_W+1:0] s;
    s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d} + (PIX_W+2)'(2);
    return s[PIX_W+1:2];
  endfunction

endpackage

>>> rtl/bu2x_if.sv
// Valid/ready channel interfaces for source pixels and output blocks.
interface bu2x_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bu2x_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface bu2x_blk_if;
  logic                       valid;
  logic                       ready;
  logic [bu2x_pkg::COL_W-1:0] block_x;
  logic [bu2x_pkg::ROW_W-1:0] block_y;
  logic [bu2x_pkg::PIX_W-1:0] out_top_left;
  logic [bu2x_pkg::PIX_W-1:0] out_top_right;
  logic [bu2x_pkg::PIX_W-1:0] out_bottom_left;
  logic [bu2x_pkg::PIX_W-1:0] out_bottom_right;
  logic                       last_of_item;
  logic                       frame_done;

  modport source (output valid, output block_x, output block_y, output out_top_left,
                  output out_top_right, output out_bottom_left,
                  output out_bottom_right, output last_of_item, output frame_done,
                  input ready);
  modport sink (input valid, input block_x, input block_y, input out_top_left,
                input out_top_right, input out_bottom_left, input out_bottom_right,
                input last_of_item, input frame_done, output ready);
endinterface

>>> rtl/bilinear_upscale_2x.sv
// Top level of the 2x bilinear upscaler: register port, front end, job queue, back end.
// The block accepts one source pixel per clock cycle while the job queue has room and
// emits one 2x2 output block per clock cycle while the sink is ready. A pixel in the
// interior of the frame yields one block, a pixel in the rightmost column or the last
// row yields up to two, and the last pixel of the last row yields up to four; the
// output register, moving one block a cycle, sets the sustained rate, and a four-entry
// job queue absorbs the bursts at row ends. A block passes through the front-end stage
// register, the job queue and the output register. The line store needs no clearing
// pass after reset. Program src_width and src_height only while no item is in flight.
module bilinear_upscale_2x (
  input  logic                          clk,
  input  logic                          rst_n,
  bu2x_pix_if.sink                      in_ch,
  bu2x_blk_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bu2x_pkg::ADDR_W-1:0]   paddr,
  input  logic [bu2x_pkg::DATA_W-1:0]   pwdata,
  output logic [bu2x_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [bu2x_pkg::SW_W-1:0] src_width_r;
  logic [bu2x_pkg::SH_W-1:0] src_height_r;

  logic                       wr_en;
  logic [bu2x_pkg::CMP_W-1:0] sw_ext;
  bu2x_pkg::geom_t            geom;
  logic                       push;
  logic                       push_ready;
  bu2x_pkg::job_t             push_job;
  logic                       head_valid;
  bu2x_pkg::job_t             head_job;
  logic                       pop;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r <= bu2x_pkg::SRC_WIDTH_RST;
      src_height_r <= bu2x_pkg::SRC_HEIGHT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        bu2x_pkg::REG_SRC_WIDTH:  src_width_r <= pwdata[bu2x_pkg::SW_W-1:0];
        bu2x_pkg::REG_SRC_HEIGHT: src_height_r <= pwdata[bu2x_pkg::SH_W-1:0];
        default:                  src_width_r <= src_width_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bu2x_pkg::REG_SRC_HEIGHT: prdata = bu2x_pkg::DATA_W'(src_height_r);
      default:                  prdata = bu2x_pkg::DATA_W'(src_width_r);
    endcase
  end

  assign sw_ext = bu2x_pkg::CMP_W'(src_width_r);

  always_comb begin
    if (src_width_r == '0) begin
      geom.wm1 = '0;
    end else if (sw_ext > bu2x_pkg::CMP_W'(bu2x_pkg::MAX_WIDTH)) begin
      geom.wm1 = bu2x_pkg::COL_W'(bu2x_pkg::MAX_WIDTH - 1);
    end else begin
      geom.wm1 = bu2x_pkg::COL_W'(sw_ext - bu2x_pkg::CMP_W'(1));
    end
    geom.hm1 = (src_height_r == '0) ? '0 : src_height_r - bu2x_pkg::SH_W'(1);
  end

  bu2x_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .in_ch      (in_ch),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  bu2x_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  bu2x_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

>>> rtl/bu2x_front.sv
// Front end: accepts pixels, keeps the line store and counters, builds block jobs.
module bu2x_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bu2x_pkg::geom_t       geom,
  bu2x_pix_if.sink              in_ch,
  output logic                  push,
  output bu2x_pkg::job_t        push_job,
  input  logic                  push_ready
);

  logic [bu2x_pkg::PIX_W-1:0] line_mem [bu2x_pkg::MAX_WIDTH];

  logic [bu2x_pkg::COL_W-1:0] col_r;
  logic [bu2x_pkg::ROW_W-1:0] row_r;
  logic                       s1_v_r;
  logic [bu2x_pkg::PIX_W-1:0] s1_cur_r;
  logic [bu2x_pkg::PIX_W-1:0] s1_above_r;
  logic [bu2x_pkg::COL_W-1:0] s1_x_r;
  logic [bu2x_pkg::ROW_W-1:0] s1_y_r;
  logic [bu2x_pkg::NBLK-1:0]  s1_blk_r;
  logic                       s1_last_col_r;
  logic [bu2x_pkg::PIX_W-1:0] left_r;
  logic [bu2x_pkg::PIX_W-1:0] left_above_r;

  logic in_fire;
  logic last_col;
  logic last_row;
  logic s1_go;
  logic [bu2x_pkg::NBLK-1:0] blk;

  assign last_col = col_r >= geom.wm1;
  assign last_row = row_r >= geom.hm1;

  always_comb begin
    blk[0] = (row_r != '0) && (col_r != '0);
    blk[1] = (row_r != '0) && last_col;
    blk[2] = last_row && (col_r != '0);
    blk[3] = last_row && last_col;
  end

  assign s1_go = s1_v_r && ((s1_blk_r == '0) || push_ready);
  assign in_ch.ready = !s1_v_r || s1_go;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_above_r <= line_mem[col_r];
      line_mem[col_r] <= in_ch.pixel_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur_r <= in_ch.pixel_value;
      s1_x_r <= col_r;
      s1_y_r <= row_r;
      s1_blk_r <= blk;
      s1_last_col_r <= last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_v_r <= 1'b0;
      left_r <= '0;
      left_above_r <= '0;
    end else begin
      if (in_fire) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + bu2x_pkg::ROW_W'(1);
        end else begin
          col_r <= col_r + bu2x_pkg::COL_W'(1);
        end
      end
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        left_r <= s1_last_col_r ? '0 : s1_cur_r;
        left_above_r <= s1_last_col_r ? '0 : s1_above_r;
      end
    end
  end

  always_comb begin
    push_job.cur = s1_cur_r;
    push_job.above = s1_above_r;
    push_job.left = left_r;
    push_job.left_above = left_above_r;
    push_job.x = s1_x_r;
    push_job.y = s1_y_r;
    push_job.blk = s1_blk_r;
  end

  assign push = s1_v_r && (s1_blk_r != '0) && push_ready;

endmodule

>>> rtl/bu2x_fifo.sv
// Short job queue between the front end and the block emitter.
module bu2x_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bu2x_pkg::job_t push_job,
  output logic           push_ready,
  output logic           head_valid,
  output bu2x_pkg::job_t head_job,
  input  logic           pop
);

  bu2x_pkg::job_t entry_r [bu2x_pkg::FIFO_DEPTH];

  logic [bu2x_pkg::FIFO_AW-1:0] wr_ptr_r;
  logic [bu2x_pkg::FIFO_AW-1:0] rd_ptr_r;
  logic [bu2x_pkg::FIFO_CW-1:0] cnt_r;

  assign push_ready = cnt_r != bu2x_pkg::FIFO_CW'(bu2x_pkg::FIFO_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_job = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + bu2x_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + bu2x_pkg::FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + bu2x_pkg::FIFO_CW'(1);
        2'b01:   cnt_r <= cnt_r - bu2x_pkg::FIFO_CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> rtl/bu2x_back.sv
// Back end: expands each job into its 2x2 blocks and holds them in the output register.
module bu2x_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  bu2x_pkg::job_t head_job,
  output logic           pop,
  bu2x_blk_if.source     out_ch
);

  logic [bu2x_pkg::NBLK-1:0] done_r;
  logic                      ov_r;
  logic [bu2x_pkg::COL_W-1:0] bx_r;
  logic [bu2x_pkg::ROW_W-1:0] by_r;
  logic [bu2x_pkg::PIX_W-1:0] tl_r;
  logic [bu2x_pkg::PIX_W-1:0] tr_r;
  logic [bu2x_pkg::PIX_W-1:0] bl_r;
  logic [bu2x_pkg::PIX_W-1:0] br_r;
  logic                       last_r;
  logic                       fdone_r;

  logic [bu2x_pkg::NBLK-1:0] rem;
  logic [bu2x_pkg::NBLK-1:0] sel;
  logic                      last;
  logic                      load;
  logic [bu2x_pkg::COL_W-1:0] bx;
  logic [bu2x_pkg::ROW_W-1:0] by;
  logic [bu2x_pkg::PIX_W-1:0] tl;
  logic [bu2x_pkg::PIX_W-1:0] tr;
  logic [bu2x_pkg::PIX_W-1:0] bl;
  logic [bu2x_pkg::PIX_W-1:0] br;
  logic                       fdone;

  assign rem = head_job.blk & ~done_r;
  assign sel = rem & (~rem + bu2x_pkg::NBLK'(1));
  assign last = (rem & ~sel) == '0;
  assign load = head_valid && (!ov_r || out_ch.ready);
  assign pop = load && last;

  always_comb begin
    fdone = 1'b0;
    case (sel)
      bu2x_pkg::BLK_UP_LEFT: begin
        bx = head_job.x - bu2x_pkg::COL_W'(1);
        by = head_job.y - bu2x_pkg::ROW_W'(1);
        tl = head_job.left_above;
        tr = head_job.above;
        bl = head_job.left;
        br = head_job.cur;
      end
      bu2x_pkg::BLK_UP_EDGE: begin
        bx = head_job.x;
        by = head_job.y - bu2x_pkg::ROW_W'(1);
        tl = head_job.above;
        tr = head_job.above;
        bl = head_job.cur;
        br = head_job.cur;
      end
      bu2x_pkg::BLK_ROW_LEFT: begin
        bx = head_job.x - bu2x_pkg::COL_W'(1);
        by = head_job.y;
        tl = head_job.left;
        tr = head_job.cur;
        bl = head_job.left;
        br = head_job.cur;
      end
      default: begin
        bx = head_job.x;
        by = head_job.y;
        tl = head_job.cur;
        tr = head_job.cur;
        bl = head_job.cur;
        br = head_job.cur;
        fdone = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bx_r <= bx;
      by_r <= by;
      tl_r <= tl;
      tr_r <= bu2x_pkg::avg2(tl, tr);
      bl_r <= bu2x_pkg::avg2(tl, bl);
      br_r <= bu2x_pkg::avg4(tl, tr, bl, br);
      last_r <= last;
      fdone_r <= fdone;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      done_r <= '0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
      if (pop) begin
        done_r <= '0;
      end else if (load) begin
        done_r <= done_r | sel;
      end
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.block_x = bx_r;
  assign out_ch.block_y = by_r;
  assign out_ch.out_top_left = tl_r;
  assign out_ch.out_top_right = tr_r;
  assign out_ch.out_bottom_left = bl_r;
  assign out_ch.out_bottom_right = br_r;
  assign out_ch.last_of_item = last_r;
  assign out_ch.frame_done = fdone_r;

  a_job_has_block: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> head_job.blk != '0)
    else $error("queued job carries no block");

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> $onehot(sel))
    else $error("block selection is not one-hot");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && fdone_r |-> last_r)
    else $error("frame end block is not the final block of its item");

  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> done_r == '0)
    else $error("emitted-block mask not cleared after pop");

endmodule
